// ===== rtl/mms_pkg.sv =====
// ----------------------------------------------------------------------------
// mms_pkg: shared constants and a helper for the menu marker scanner
// Byte codes, register indexes and the name character class.
// ----------------------------------------------------------------------------
package mms_pkg;

    // Default for MAX_NAME, the per-bank name buffer depth
    localparam int MAX_NAME_DEFAULT = 16;

    // Field and port widths
    localparam int BYTE_W      = 8;
    localparam int CHAR_W      = 7;
    localparam int ADDR_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int OUT_DATA_W  = 24;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA_LENGTH  = 1'b1;

    // Marker bytes
    localparam logic [BYTE_W-1:0] PROLOG_BYTE = 8'h7F;
    localparam logic [BYTE_W-1:0] EPILOG_MAX  = 8'h1F;
    localparam logic [BYTE_W-1:0] COLON_BYTE  = 8'h3A;

    // Letters, digits and colon may form a name
    function automatic logic name_ok(input logic [BYTE_W-1:0] b);
        logic ok;
        ok = ((b >= 8'h30) && (b <= 8'h39))
          || ((b >= 8'h41) && (b <= 8'h5A))
          || ((b >= 8'h61) && (b <= 8'h7A))
          || (b == COLON_BYTE);
        return ok;
    endfunction

endpackage

// ===== rtl/mms_queue.sv =====
// ----------------------------------------------------------------------------
// mms_queue: two-slot entry queue between scanner front and emitter back
// Each slot owns one bank of the name buffer; the slot pointer is the bank.
// ----------------------------------------------------------------------------
module mms_queue #(
    parameter int CNT_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [mms_pkg::ADDR_W-1:0]  push_addr,
    input  logic [CNT_W-1:0]            push_count,
    input  logic                        push_trunc,
    input  logic                        pop,
    output logic                        full,
    output logic                        empty,
    output logic                        wr_slot,
    output logic                        rd_slot,
    output logic [mms_pkg::ADDR_W-1:0]  head_addr,
    output logic [CNT_W-1:0]            head_count,
    output logic                        head_trunc
);
    import mms_pkg::*;

    logic [ADDR_W-1:0] addr_reg  [2];
    logic [CNT_W-1:0]  count_reg [2];
    logic              trunc_reg [2];

    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop  ? ~rptr_reg : rptr_reg;
        fill_next = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            addr_reg[wptr_reg]  <= push_addr;
            count_reg[wptr_reg] <= push_count;
            trunc_reg[wptr_reg] <= push_trunc;
        end
    end

    assign full       = (fill_reg == 2'd2);
    assign empty      = (fill_reg == 2'd0);
    assign wr_slot    = wptr_reg;
    assign rd_slot    = rptr_reg;
    assign head_addr  = addr_reg[rptr_reg];
    assign head_count = count_reg[rptr_reg];
    assign head_trunc = trunc_reg[rptr_reg];

endmodule

// ===== rtl/mms_front.sv =====
// ----------------------------------------------------------------------------
// mms_front: byte classifier and prolog/name/epilog scanner
// Holds the configuration, tracks the byte position and collects name chars.
// ----------------------------------------------------------------------------
module mms_front #(
    parameter int MAX_NAME = mms_pkg::MAX_NAME_DEFAULT,
    parameter int CNT_W    = 5,
    parameter int IDX_W    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [mms_pkg::BYTE_W-1:0]      in_byte,
    input  logic                            q_full,
    output logic                            push,
    output logic [mms_pkg::ADDR_W-1:0]      push_addr,
    output logic [CNT_W-1:0]                push_count,
    output logic                            push_trunc,
    output logic                            wr_en,
    output logic [IDX_W-1:0]                wr_idx,
    output logic [mms_pkg::CHAR_W-1:0]      wr_char
);
    import mms_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_HALF = 3'b010,
        PH_NAME = 3'b100
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [15:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [ADDR_W-1:0] load_reg;
    logic [15:0]       len_reg;

    logic accept;
    logic name_room;
    logic prolog_room;
    logic is_prolog;

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign name_room   = ({1'b0, pos_reg} + 17'd1) < {1'b0, len_reg};
    assign prolog_room = ({1'b0, pos_reg} + 17'd4) < {1'b0, len_reg};
    assign is_prolog   = (in_byte == PROLOG_BYTE);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        push       = 1'b0;
        wr_en      = 1'b0;
        if (accept && (pos_reg < len_reg))
        begin
            if (pos_reg != 16'hFFFF)
            begin
                pos_next = pos_reg + 16'd1;
            end
            case (phase_reg)
                PH_NAME:
                begin
                    if (name_room && name_ok(in_byte))
                    begin
                        if (count_reg < CNT_W'(MAX_NAME))
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else
                    begin
                        // epilog byte: consumed whatever it is
                        push       = (in_byte <= EPILOG_MAX) && (count_reg != '0);
                        phase_next = PH_IDLE;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
                PH_HALF:
                begin
                    if (is_prolog)
                    begin
                        phase_next = PH_NAME;
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_IDLE:
                begin
                    phase_next = (is_prolog && prolog_room) ? PH_HALF : PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    assign push_addr  = load_reg + pos_reg + 16'd1;
    assign push_count = count_reg;
    assign push_trunc = ovf_reg;
    assign wr_idx     = count_reg[IDX_W-1:0];
    assign wr_char    = in_byte[CHAR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= 16'd0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            load_reg  <= 16'd0;
            len_reg   <= 16'd1;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_we && (cfg_index == REG_LOAD_ADDRESS))
            begin
                load_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_DATA_LENGTH))
            begin
                len_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ===== rtl/mms_back.sv =====
// ----------------------------------------------------------------------------
// mms_back: name buffer and character emitter
// Reads queued entries out of the banked name buffer into the output register.
// ----------------------------------------------------------------------------
module mms_back #(
    parameter int MAX_NAME = mms_pkg::MAX_NAME_DEFAULT,
    parameter int CNT_W    = 5,
    parameter int IDX_W    = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic                            wr_bank,
    input  logic [IDX_W-1:0]                wr_idx,
    input  logic [mms_pkg::CHAR_W-1:0]      wr_char,
    input  logic                            q_empty,
    input  logic                            rd_bank,
    input  logic [mms_pkg::ADDR_W-1:0]      head_addr,
    input  logic [CNT_W-1:0]                head_count,
    input  logic                            head_trunc,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mms_pkg::CHAR_W-1:0]      out_char,
    output logic [mms_pkg::ADDR_W-1:0]      out_addr,
    output logic                            out_last,
    output logic                            out_trunc
);
    import mms_pkg::*;

    localparam int DEPTH = 2 * MAX_NAME;
    localparam int MEM_W = $clog2(DEPTH);

    logic [CHAR_W-1:0] name_mem [DEPTH];

    logic [IDX_W-1:0]  k_reg, k_next;
    logic              rd_valid_reg;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              rd_last_reg;
    logic              rd_trunc_reg;
    logic              out_valid_reg;

    logic              issue;
    logic              is_last;
    logic [MEM_W-1:0]  wr_ptr;
    logic [MEM_W-1:0]  rd_ptr;

    assign issue   = !q_empty && !rd_valid_reg && (!out_valid_reg || out_ready);
    assign is_last = ((CNT_W'(k_reg) + CNT_W'(1)) == head_count);
    assign pop     = issue && is_last;
    assign k_next  = is_last ? '0 : k_reg + IDX_W'(1);

    assign wr_ptr = wr_bank ? MEM_W'(MAX_NAME) + MEM_W'(wr_idx) : MEM_W'(wr_idx);
    assign rd_ptr = rd_bank ? MEM_W'(MAX_NAME) + MEM_W'(k_reg)  : MEM_W'(k_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            name_mem[wr_ptr] <= wr_char;
        end
        if (issue)
        begin
            rd_char_reg  <= name_mem[rd_ptr];
            rd_addr_reg  <= head_addr;
            rd_last_reg  <= is_last;
            rd_trunc_reg <= head_trunc;
        end
        if (rd_valid_reg)
        begin
            out_char  <= rd_char_reg;
            out_addr  <= rd_addr_reg;
            out_last  <= rd_last_reg;
            out_trunc <= rd_trunc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                k_reg <= k_next;
            end
            rd_valid_reg <= issue;
            if (rd_valid_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/menu_marker_scanner_top.sv =====
// ----------------------------------------------------------------------------
// menu_marker_scanner_top: menu entry scanner over program image bytes
// Finds prolog/name/epilog menu markers and streams out the name characters.
// ----------------------------------------------------------------------------
// Feed the program bytes of an image, one per transaction, from position
// zero; set load_address and data_length beforehand. An input byte is
// accepted whenever the entry queue has room. When an entry ends, its name
// characters leave one per transaction, every character carrying the entry
// address, tlast on the final character and tuser set when the name was
// longer than MAX_NAME and cut. The emitter reads the name buffer through
// one registered read port, issuing no read while the last character is
// still in the read register. The queue holds two finished entries, one per
// buffer bank; input stalls only when both banks hold names not yet fully sent.
// ----------------------------------------------------------------------------
module menu_marker_scanner_top #(
    parameter int MAX_NAME = mms_pkg::MAX_NAME_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mms_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [6:0] name_char,
                                                            // [22:7] entry_address
    output logic                            m_axis_tlast,   // last_char
    output logic                            m_axis_tuser    // [0] truncated
);
    import mms_pkg::*;

    // count must hold MAX_NAME itself, index covers 0..MAX_NAME-1
    localparam int CNT_W = $clog2(MAX_NAME + 1);
    localparam int IDX_W = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

    logic              full;
    logic              empty;
    logic              wr_slot;
    logic              rd_slot;
    logic              push;
    logic              pop;
    logic [ADDR_W-1:0] push_addr;
    logic [CNT_W-1:0]  push_count;
    logic              push_trunc;
    logic [ADDR_W-1:0] head_addr;
    logic [CNT_W-1:0]  head_count;
    logic              head_trunc;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    logic [CHAR_W-1:0] wr_char;
    logic [CHAR_W-1:0] out_char;
    logic [ADDR_W-1:0] out_addr;

    // Classify bytes, track the scan phase and fill the current bank
    mms_front #(
        .MAX_NAME (MAX_NAME),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .q_full     (full),
        .push       (push),
        .push_addr  (push_addr),
        .push_count (push_count),
        .push_trunc (push_trunc),
        .wr_en      (wr_en),
        .wr_idx     (wr_idx),
        .wr_char    (wr_char)
    );

    // Hold finished entries until the emitter has drained their bank
    mms_queue #(
        .CNT_W (CNT_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_addr  (push_addr),
        .push_count (push_count),
        .push_trunc (push_trunc),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .wr_slot    (wr_slot),
        .rd_slot    (rd_slot),
        .head_addr  (head_addr),
        .head_count (head_count),
        .head_trunc (head_trunc)
    );

    // Read names out of the buffer and drive the output register
    mms_back #(
        .MAX_NAME (MAX_NAME),
        .CNT_W    (CNT_W),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_bank    (wr_slot),
        .wr_idx     (wr_idx),
        .wr_char    (wr_char),
        .q_empty    (empty),
        .rd_bank    (rd_slot),
        .head_addr  (head_addr),
        .head_count (head_count),
        .head_trunc (head_trunc),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_char   (out_char),
        .out_addr   (out_addr),
        .out_last   (m_axis_tlast),
        .out_trunc  (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, out_addr, out_char};

`ifndef SYNTHESIS
    // The front never finishes an entry while both banks are taken
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("entry pushed into a full queue");

    // The emitter never retires an entry that was not queued
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("entry popped from an empty queue");

    // The queue fills only through a finished entry
    assert property (@(posedge clk) disable iff (!rst_n) (!full && !push) |=> !full)
        else $error("queue became full without a push");

    // Input is held off exactly while both banks are in use
    assert property (@(posedge clk) disable iff (!rst_n) s_axis_tready == !full)
        else $error("input ready out of step with queue state");
`endif

endmodule
